[rtl/core/bcs_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and helpers for the boxcar / first-order smoother block.
package bcs_pkg;

    localparam int SAMPLE_BITS    = 16;
    localparam int MAX_WINDOW_DEF = 32;
    localparam int WIN_SHORT_REQ  = 16;
    localparam int WIN_LONG_REQ   = 32;

    // A 32-sample sum of SAMPLE_BITS samples needs five more bits, signed.
    localparam int SUM_W = SAMPLE_BITS + 5;
    localparam int MAG_W = SAMPLE_BITS + 5;

    localparam int GAIN_W    = 17;
    localparam int FRAC_BITS = 16;
    localparam logic [GAIN_W-1:0] GAIN_ONE   = 17'h10000;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 17'd6554;

    localparam int MODE_W = 2;
    localparam logic [MODE_W-1:0] MODE_SMOOTH    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_AVG_SHORT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_AVG_LONG  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_RESET     = MODE_AVG_SHORT;

    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam logic REG_MODE = 1'b0;
    localparam logic REG_GAIN = 1'b1;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_in;
        logic                          record_start;
    } t_in_req;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] filtered_out;
        logic                          out_valid;
    } t_out_req;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [GAIN_W-1:0] gain;
    } t_cfg;

    typedef struct packed {
        logic [MAG_W-1:0]              mag;
        logic                          neg;
        logic                          use_div;
        logic                          long_win;
        logic signed [SAMPLE_BITS-1:0] direct;
        logic                          ov;
    } t_avg_item;

    function automatic int unsigned win_clamp(int unsigned max_win, int unsigned req);
        return (req > max_win) ? max_win : req;
    endfunction

endpackage

[rtl/core/bcs_ram.sv]
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered, read-first output.
module bcs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/bcs_window.sv]
`timescale 1ns / 1ps
// Sample history memory, running window sums and the first-order recursion.
module bcs_window #(
    parameter int MAX_WINDOW = bcs_pkg::MAX_WINDOW_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bcs_pkg::t_cfg       i_cfg,
    input  logic                i_in_valid,
    input  bcs_pkg::t_in_req    i_in_req,
    output logic                o_in_stall,
    output logic                o_item_valid,
    output bcs_pkg::t_avg_item  o_item,
    input  logic                i_item_stall
);

    localparam int SB      = bcs_pkg::SAMPLE_BITS;
    localparam int SUM_W   = bcs_pkg::SUM_W;
    localparam int GAIN_W  = bcs_pkg::GAIN_W;
    localparam int PROD_W  = GAIN_W + SB + 2;
    localparam int PTR_W   = $clog2(MAX_WINDOW);
    localparam int FILL_W  = $clog2(MAX_WINDOW + 1);
    localparam int W_SHORT = bcs_pkg::win_clamp(MAX_WINDOW, bcs_pkg::WIN_SHORT_REQ);
    localparam int W_LONG  = bcs_pkg::win_clamp(MAX_WINDOW, bcs_pkg::WIN_LONG_REQ);

    // Pointer and fill count advance at acceptance.
    logic [PTR_W-1:0]  r_wp, n_wp;
    logic [FILL_W-1:0] r_fill, n_fill;
    logic [PTR_W-1:0]  wp_eff;
    logic [FILL_W-1:0] fill_eff;
    logic [PTR_W:0]    addr_short_raw, addr_long_raw;
    logic [PTR_W-1:0]  addr_short, addr_long;
    logic              accept;

    // Compute stage registers.
    logic                 r_v1;
    logic signed [SB-1:0] r_x1;
    logic                 r_start1;
    logic [FILL_W-1:0]    r_fill1;

    logic [SB-1:0] rd_short, rd_long;

    logic signed [SUM_W-1:0] r_sum_short, n_sum_short;
    logic signed [SUM_W-1:0] r_sum_long, n_sum_long;
    logic signed [SB-1:0]    r_smooth, n_smooth;

    logic                    adv1;
    logic [FILL_W-1:0]       fill_new;
    logic signed [SUM_W-1:0] leave_short, leave_long, base_short, base_long, sel_sum;
    logic [GAIN_W-1:0]       gain_c;
    logic signed [SB:0]      diff;
    logic signed [PROD_W-1:0] prod;
    logic                    avg_mode, full;
    bcs_pkg::t_avg_item      item;

    assign accept     = i_in_valid && !o_in_stall;
    assign o_in_stall = r_v1 && i_item_stall;
    assign adv1       = r_v1 && !i_item_stall;

    always_comb begin
        wp_eff   = i_in_req.record_start ? '0 : r_wp;
        fill_eff = i_in_req.record_start ? '0 : r_fill;
        n_wp     = (wp_eff == PTR_W'(MAX_WINDOW - 1)) ? '0 : wp_eff + 1'b1;
        n_fill   = (fill_eff == FILL_W'(MAX_WINDOW)) ? fill_eff : fill_eff + 1'b1;

        // Address of the sample that leaves each window, modulo the store depth.
        addr_short_raw = {1'b0, wp_eff} + (PTR_W + 1)'(MAX_WINDOW - W_SHORT);
        addr_long_raw  = {1'b0, wp_eff} + (PTR_W + 1)'(MAX_WINDOW - W_LONG);
        if (addr_short_raw >= (PTR_W + 1)'(MAX_WINDOW)) begin
            addr_short_raw = addr_short_raw - (PTR_W + 1)'(MAX_WINDOW);
        end
        if (addr_long_raw >= (PTR_W + 1)'(MAX_WINDOW)) begin
            addr_long_raw = addr_long_raw - (PTR_W + 1)'(MAX_WINDOW);
        end
        addr_short = addr_short_raw[PTR_W-1:0];
        addr_long  = addr_long_raw[PTR_W-1:0];
    end

    // Both copies take every sample; each serves one read address.
    bcs_ram #(.WIDTH(SB), .DEPTH(MAX_WINDOW)) u_ram_short (
        .i_clk   (i_clk),
        .i_we    (accept),
        .i_waddr (wp_eff),
        .i_wdata (i_in_req.sample_in),
        .i_re    (accept),
        .i_raddr (addr_short),
        .o_rdata (rd_short)
    );

    bcs_ram #(.WIDTH(SB), .DEPTH(MAX_WINDOW)) u_ram_long (
        .i_clk   (i_clk),
        .i_we    (accept),
        .i_waddr (wp_eff),
        .i_wdata (i_in_req.sample_in),
        .i_re    (accept),
        .i_raddr (addr_long),
        .o_rdata (rd_long)
    );

    always_comb begin
        fill_new = (r_fill1 == FILL_W'(MAX_WINDOW)) ? r_fill1 : r_fill1 + 1'b1;

        // Entries older than the current record read as zero.
        leave_short = (r_fill1 >= FILL_W'(W_SHORT)) ? SUM_W'($signed(rd_short)) : '0;
        leave_long  = (r_fill1 >= FILL_W'(W_LONG)) ? SUM_W'($signed(rd_long)) : '0;
        base_short  = r_start1 ? '0 : r_sum_short;
        base_long   = r_start1 ? '0 : r_sum_long;
        n_sum_short = base_short + SUM_W'(r_x1) - leave_short;
        n_sum_long  = base_long + SUM_W'(r_x1) - leave_long;

        // y + floor(alpha * (x - y) / 2^16) equals the weighted form exactly.
        gain_c = (i_cfg.gain > bcs_pkg::GAIN_ONE) ? bcs_pkg::GAIN_ONE : i_cfg.gain;
        diff   = (SB + 1)'(r_x1) - (SB + 1)'(r_smooth);
        prod   = $signed({1'b0, gain_c}) * diff;
        if (r_start1) begin
            n_smooth = '0;
        end else if (i_cfg.mode == bcs_pkg::MODE_SMOOTH) begin
            n_smooth = r_smooth + SB'(prod >>> bcs_pkg::FRAC_BITS);
        end else begin
            n_smooth = r_smooth;
        end

        avg_mode = 1'b0;
        full     = 1'b0;
        sel_sum  = n_sum_short;
        item     = '0;
        case (i_cfg.mode)
            bcs_pkg::MODE_SMOOTH: begin
                item.direct = n_smooth;
                item.ov     = 1'b1;
            end
            bcs_pkg::MODE_AVG_SHORT: begin
                avg_mode = 1'b1;
                full     = fill_new >= FILL_W'(W_SHORT);
            end
            bcs_pkg::MODE_AVG_LONG: begin
                avg_mode      = 1'b1;
                full          = fill_new >= FILL_W'(W_LONG);
                sel_sum       = n_sum_long;
                item.long_win = 1'b1;
            end
            default: begin
                avg_mode = 1'b0;
            end
        endcase
        if (avg_mode) begin
            item.ov      = full;
            item.use_div = full;
            item.neg     = sel_sum[SUM_W-1];
            item.mag     = sel_sum[SUM_W-1] ? unsigned'(-sel_sum) : unsigned'(sel_sum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp        <= '0;
            r_fill      <= '0;
            r_v1        <= 1'b0;
            r_sum_short <= '0;
            r_sum_long  <= '0;
            r_smooth    <= '0;
        end else begin
            if (accept) begin
                r_wp   <= n_wp;
                r_fill <= n_fill;
                r_v1   <= 1'b1;
            end else if (adv1) begin
                r_v1 <= 1'b0;
            end
            if (adv1) begin
                r_sum_short <= n_sum_short;
                r_sum_long  <= n_sum_long;
                r_smooth    <= n_smooth;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_x1     <= i_in_req.sample_in;
            r_start1 <= i_in_req.record_start;
            r_fill1  <= fill_eff;
        end
    end

    assign o_item_valid = r_v1;
    assign o_item       = item;

endmodule

[rtl/core/bcs_divide.sv]
`timescale 1ns / 1ps
// Truncating divide of the window sum by its length, and the output register.
module bcs_divide #(
    parameter int MAX_WINDOW = bcs_pkg::MAX_WINDOW_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_item_valid,
    input  bcs_pkg::t_avg_item  i_item,
    output logic                o_item_stall,
    output logic                o_out_valid,
    output bcs_pkg::t_out_req   o_out_req,
    input  logic                i_out_stall
);

    localparam int SB      = bcs_pkg::SAMPLE_BITS;
    localparam int MAG_W   = bcs_pkg::MAG_W;
    localparam int RCP_W   = MAG_W - 3;
    localparam int W_SHORT = bcs_pkg::win_clamp(MAX_WINDOW, bcs_pkg::WIN_SHORT_REQ);
    localparam int W_LONG  = bcs_pkg::win_clamp(MAX_WINDOW, bcs_pkg::WIN_LONG_REQ);
    localparam logic [RCP_W-1:0] RCP_SHORT = RCP_W'((64'd1 << MAG_W) / W_SHORT);
    localparam logic [RCP_W-1:0] RCP_LONG  = RCP_W'((64'd1 << MAG_W) / W_LONG);
    localparam logic [MAG_W-1:0] N_SHORT   = MAG_W'(W_SHORT);
    localparam logic [MAG_W-1:0] N_LONG    = MAG_W'(W_LONG);

    logic               r_v2, r_v3, r_vo;
    bcs_pkg::t_avg_item r_item2, r_item3;
    logic [RCP_W-1:0]   r_q0;
    bcs_pkg::t_out_req  r_out;

    logic rdy_o, rdy3, rdy2, adv2, adv3;

    logic [RCP_W-1:0]       recip;
    logic [MAG_W+RCP_W-1:0] prod;
    logic [MAG_W-1:0]       n_sel, q0_ext, qn, rem, q, res;
    bcs_pkg::t_out_req      n_out;

    assign rdy_o        = !r_vo || !i_out_stall;
    assign rdy3         = !r_v3 || rdy_o;
    assign rdy2         = !r_v2 || rdy3;
    assign adv3         = r_v3 && rdy_o;
    assign adv2         = r_v2 && rdy3;
    assign o_item_stall = !rdy2;

    // Quotient estimate by reciprocal; it is low by at most one.
    always_comb begin
        recip = r_item2.long_win ? RCP_LONG : RCP_SHORT;
        prod  = (MAG_W + RCP_W)'(r_item2.mag) * (MAG_W + RCP_W)'(recip);
    end

    always_comb begin
        n_sel  = r_item3.long_win ? N_LONG : N_SHORT;
        q0_ext = MAG_W'(r_q0);
        qn     = q0_ext * n_sel;
        rem    = r_item3.mag - qn;
        q      = (rem >= n_sel) ? q0_ext + 1'b1 : q0_ext;
        res    = r_item3.neg ? -q : q;
        n_out.out_valid    = r_item3.ov;
        n_out.filtered_out = r_item3.use_div ? $signed(res[SB-1:0]) : r_item3.direct;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (rdy2) begin
                r_v2 <= i_item_valid;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
            if (rdy_o) begin
                r_vo <= r_v3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy2 && i_item_valid) begin
            r_item2 <= i_item;
        end
        if (adv2) begin
            r_item3 <= r_item2;
            r_q0    <= prod[MAG_W+RCP_W-1:MAG_W];
        end
        if (adv3) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_vo;
    assign o_out_req   = r_out;

endmodule

[rtl/core/boxcar_or_first_order_smoother_top.sv]
`timescale 1ns / 1ps
// Top level: 16/32-sample boxcar average or first-order smoother, APB setup.
// Throughput is one request per clock unless a stalled output fills every stage; a result
// reaches the output register through memory read, divide estimate and correction.
// Synchronous active-low reset clears control state and sets the mode to the short
// average with gain 6554; the history reads as empty through the fill count.
module boxcar_or_first_order_smoother_top #(
    parameter int MAX_WINDOW = bcs_pkg::MAX_WINDOW_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bcs_pkg::ADDR_W-1:0]  paddr,
    input  logic [bcs_pkg::DATA_W-1:0]  pwdata,
    output logic [bcs_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    input  logic                        i_in_valid,
    input  bcs_pkg::t_in_req            i_in_req,
    output logic                        o_in_stall,
    output logic                        o_out_valid,
    output bcs_pkg::t_out_req           o_out_req,
    input  logic                        i_out_stall
);

    // Configuration registers. Register 0 (mode) sits at byte address 0 and
    // register 1 (smoother gain) at byte address 4; only address bit 2 decodes.
    logic [bcs_pkg::MODE_W-1:0] r_mode;
    logic [bcs_pkg::GAIN_W-1:0] r_gain;
    logic                       cfg_wr;
    bcs_pkg::t_cfg              cfg;

    logic               item_valid, item_stall;
    bcs_pkg::t_avg_item item;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= bcs_pkg::MODE_RESET;
            r_gain <= bcs_pkg::GAIN_RESET;
        end else if (cfg_wr) begin
            case (paddr[2])
                bcs_pkg::REG_MODE: r_mode <= pwdata[bcs_pkg::MODE_W-1:0];
                bcs_pkg::REG_GAIN: r_gain <= pwdata[bcs_pkg::GAIN_W-1:0];
                default: r_mode <= r_mode;
            endcase
        end
    end

    // Reads return the stored value, zero-extended to the bus width.
    always_comb begin
        case (paddr[2])
            bcs_pkg::REG_MODE: prdata = bcs_pkg::DATA_W'(r_mode);
            bcs_pkg::REG_GAIN: prdata = bcs_pkg::DATA_W'(r_gain);
            default:           prdata = '0;
        endcase
    end

    assign cfg.mode = r_mode;
    assign cfg.gain = r_gain;

    // The window stage owns the history memories, running sums and the
    // recursion; each sample writes its slot and reads the slots that
    // leave the short and long windows in the same cycle.
    bcs_window #(.MAX_WINDOW(MAX_WINDOW)) u_window (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_in_valid   (i_in_valid),
        .i_in_req     (i_in_req),
        .o_in_stall   (o_in_stall),
        .o_item_valid (item_valid),
        .o_item       (item),
        .i_item_stall (item_stall)
    );

    // The divide stage turns the window sum into a truncated average and
    // holds the finished result in the output register; its bubbles
    // collapse, so a waiting result holds back new requests only once
    // every stage is full.
    bcs_divide #(.MAX_WINDOW(MAX_WINDOW)) u_divide (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (item_valid),
        .i_item       (item),
        .o_item_stall (item_stall),
        .o_out_valid  (o_out_valid),
        .o_out_req    (o_out_req),
        .i_out_stall  (i_out_stall)
    );

endmodule

[test/tb_boxcar_or_first_order_smoother_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the boxcar average / first-order smoother block.
module tb_boxcar_or_first_order_smoother_top;
    import bcs_pkg::*;

    // Mode 3 has no filter behind it; the block must answer with an empty result.
    localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;
    // Largest value the 17-bit gain register can hold, well above unity gain.
    localparam logic [GAIN_W-1:0] GAIN_TOP  = 17'h1FFFF;
    localparam logic [ADDR_W-1:0] MODE_ADDR = {REG_MODE, 2'b00};
    localparam logic [ADDR_W-1:0] GAIN_ADDR = {REG_GAIN, 2'b00};
    localparam int HIST_DEPTH = MAX_WINDOW_DEF;
    // Idle margin after the last owed result, so that the pipeline stages go empty.
    localparam int SETTLE_CYCLES = 8;
    localparam int LONG_HOLD = 80;
    localparam int RANDOM_PHASES = 14;
    localparam int PHASE_REQUESTS = 91;
    localparam int PRESSURE_PHASE = 5;
    localparam int DRAIN_LIMIT = 5000;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [ADDR_W-1:0]    paddr;
    logic [DATA_W-1:0]    pwdata;
    logic [DATA_W-1:0]    prdata;
    logic                 pready;
    logic                 i_in_valid;
    t_in_req              i_in_req;
    logic                 o_in_stall;
    logic                 o_out_valid;
    t_out_req             o_out_req;
    logic                 i_out_stall;

    boxcar_or_first_order_smoother_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .i_in_valid  (i_in_valid),
        .i_in_req    (i_in_req),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_req   (o_out_req),
        .i_out_stall (i_out_stall)
    );

    always #2 i_clk = ~i_clk;

    // Hard stop in case the block hangs and a handshake never completes.
    initial begin : watchdog
        #2000000;
        $display("FAILED: results differ");
        $finish;
    end

    // Filter state mirrored on the testbench side. The settings copy is only
    // updated while the block is idle, so it always matches what the block
    // applied to the request being predicted.
    logic signed [SAMPLE_BITS-1:0] history [HIST_DEPTH];
    int                            fill_level;
    int                            slot;
    logic signed [SAMPLE_BITS-1:0] smooth_state;
    logic [MODE_W-1:0]             cur_mode;
    logic [GAIN_W-1:0]             cur_gain;

    // Filtered samples still owed by the block, oldest first.
    t_out_req filtered_ahead [$];

    int  bad_count;
    int  outputs_seen;
    int  requests_fed;
    int  records_opened;
    int  settings_used;
    int  holds_done;
    int  mode_hits [4];
    bit  gaps_on;
    int  burst_left;
    bit  hold_req;

    // One row of the directed script. A row repeats its sample; the record
    // start, if set, applies to the first repetition only. Rows that carry a
    // typed result use it in place of the predicted one.
    typedef struct packed {
        logic [MODE_W-1:0]             mode;
        logic [GAIN_W-1:0]             gain;
        logic signed [SAMPLE_BITS-1:0] x;
        logic                          opens;
        int                            reps;
        logic                          typed;
        t_out_req                      want;
    } t_script_row;

    t_script_row script [22] = '{
        // Reset settings, no record start yet: the window fills from zero history.
        '{MODE_AVG_SHORT, GAIN_RESET, 16'sh7FFF, 1'b0, 1,  1'b1, '{16'sd0, 1'b0}},
        '{MODE_AVG_SHORT, GAIN_RESET, 16'sh7FFF, 1'b0, 14, 1'b1, '{16'sd0, 1'b0}},
        // Sixteenth sample completes the short window of full-scale positives.
        '{MODE_AVG_SHORT, GAIN_RESET, 16'sh7FFF, 1'b0, 1,  1'b1, '{16'sh7FFF, 1'b1}},
        '{MODE_AVG_SHORT, GAIN_RESET, 16'sh8000, 1'b0, 16, 1'b0, '{16'sd0, 1'b0}},
        // Switch to the long window inside the same record; it is already full.
        '{MODE_AVG_LONG,  GAIN_RESET, 16'sd3,    1'b0, 1,  1'b0, '{16'sd0, 1'b0}},
        // New record of full-scale negatives: nothing valid until 32 samples.
        '{MODE_AVG_LONG,  GAIN_RESET, 16'sh8000, 1'b1, 31, 1'b1, '{16'sd0, 1'b0}},
        '{MODE_AVG_LONG,  GAIN_RESET, 16'sh8000, 1'b0, 1,  1'b1, '{16'sh8000, 1'b1}},
        // Negative sum that does not divide evenly: truncates toward zero.
        '{MODE_AVG_LONG,  GAIN_RESET, 16'sd1,    1'b0, 1,  1'b0, '{16'sd0, 1'b0}},
        // Undefined mode gives an empty, invalid result.
        '{MODE_NONE,      GAIN_RESET, 16'sd12345, 1'b0, 2, 1'b1, '{16'sd0, 1'b0}},
        // Smoother at unity gain: the record's first sample gives zero, then y = x.
        '{MODE_SMOOTH,    GAIN_ONE,   16'sh8000, 1'b1, 1,  1'b1, '{16'sd0, 1'b1}},
        '{MODE_SMOOTH,    GAIN_ONE,   16'sh8000, 1'b0, 1,  1'b1, '{16'sh8000, 1'b1}},
        '{MODE_SMOOTH,    GAIN_ONE,   16'sh7FFF, 1'b0, 1,  1'b1, '{16'sh7FFF, 1'b1}},
        // Gain above one behaves as unity gain.
        '{MODE_SMOOTH,    GAIN_TOP,   -16'sd5,   1'b0, 1,  1'b1, '{-16'sd5, 1'b1}},
        // Zero gain holds the last output whatever comes in.
        '{MODE_SMOOTH,    17'd0,      16'sh7FFF, 1'b0, 3,  1'b1, '{-16'sd5, 1'b1}},
        // Smallest gain: the floor of the shift decides the result.
        '{MODE_SMOOTH,    17'd1,      16'sh7FFF, 1'b0, 4,  1'b0, '{16'sd0, 1'b0}},
        '{MODE_SMOOTH,    17'd1,      16'sh8000, 1'b0, 4,  1'b0, '{16'sd0, 1'b0}},
        '{MODE_SMOOTH,    GAIN_RESET, 16'sh8000, 1'b0, 8,  1'b0, '{16'sd0, 1'b0}},
        '{MODE_SMOOTH,    GAIN_RESET, 16'sd100,  1'b1, 1,  1'b1, '{16'sd0, 1'b1}},
        '{MODE_SMOOTH,    17'd65535,  16'sh5555, 1'b0, 3,  1'b0, '{16'sd0, 1'b0}},
        // Back to averaging within the record that the smoother started.
        '{MODE_AVG_SHORT, GAIN_RESET, 16'sd7,    1'b0, 16, 1'b0, '{16'sd0, 1'b0}},
        '{MODE_AVG_SHORT, GAIN_RESET, -16'sd1,   1'b1, 16, 1'b0, '{16'sd0, 1'b0}},
        // Sum of -15 over 16 must give 0, not -1.
        '{MODE_AVG_SHORT, GAIN_RESET, 16'sd0,    1'b0, 1,  1'b0, '{16'sd0, 1'b0}}
    };

    task automatic flag_error(input string msg);
        bad_count++;
        $display("mismatch at %0t ns: %s", $time, msg);
    endtask

    // Empties the history, as after reset or at the start of a record.
    function automatic void clear_history();
        foreach (history[k]) begin
            history[k] = '0;
        end
        fill_level   = 0;
        slot         = 0;
        smooth_state = '0;
    endfunction

    // Works out the filtered sample that one request must produce and moves
    // the mirrored state on by one sample.
    function automatic t_out_req smooth_or_average(input t_in_req r);
        t_out_req y;
        int       span;
        int       total;
        longint   alpha;
        longint   acc;
        y = '0;
        if (r.record_start) begin
            clear_history();
        end
        // Every mode stores the sample, so a later mode switch sees it.
        history[slot] = r.sample_in;
        if (fill_level < HIST_DEPTH) begin
            fill_level++;
        end
        case (cur_mode)
            MODE_AVG_SHORT, MODE_AVG_LONG: begin
                span = (cur_mode == MODE_AVG_SHORT) ? WIN_SHORT_REQ : WIN_LONG_REQ;
                if (span > HIST_DEPTH) begin
                    span = HIST_DEPTH;
                end
                total = 0;
                for (int k = 0; k < span; k++) begin
                    total += history[(slot + HIST_DEPTH - k) % HIST_DEPTH];
                end
                // Integer division truncates toward zero, as the block does.
                if (fill_level >= span) begin
                    y.filtered_out = SAMPLE_BITS'(total / span);
                    y.out_valid    = 1'b1;
                end
            end
            MODE_SMOOTH: begin
                if (!r.record_start) begin
                    alpha = (cur_gain > GAIN_ONE) ? longint'(GAIN_ONE) : longint'(cur_gain);
                    acc   = (longint'(GAIN_ONE) - alpha) * longint'(smooth_state)
                          + alpha * longint'(r.sample_in);
                    // Arithmetic shift floors negative values.
                    smooth_state = SAMPLE_BITS'(acc >>> FRAC_BITS);
                end
                y.filtered_out = smooth_state;
                y.out_valid    = 1'b1;
            end
            default: ;
        endcase
        slot = (slot + 1) % HIST_DEPTH;
        return y;
    endfunction

    // One register access: a setup cycle, then an access cycle that completes
    // on pready. An idle cycle follows so back-to-back calls never drive psel
    // twice in one time step.
    task automatic apb_access(input logic [ADDR_W-1:0] addr, input logic wr,
                              input logic [DATA_W-1:0] wdata,
                              output logic [DATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // Lowers valid and waits until every owed result is out and the pipeline
    // has had time to go quiet.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (filtered_ahead.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Rewrites both registers, with a read-back, whenever a phase needs new
    // settings. Only ever called with the block idle.
    task automatic program_filter(input logic [MODE_W-1:0] mode,
                                  input logic [GAIN_W-1:0] gain);
        logic [DATA_W-1:0] rd;
        if (mode == cur_mode && gain == cur_gain) begin
            return;
        end
        settle();
        apb_access(MODE_ADDR, 1'b1, DATA_W'(mode), rd);
        apb_access(MODE_ADDR, 1'b0, '0, rd);
        if (rd[MODE_W-1:0] !== mode) begin
            flag_error($sformatf("mode reads back %0d, wrote %0d", rd[MODE_W-1:0], mode));
        end
        apb_access(GAIN_ADDR, 1'b1, DATA_W'(gain), rd);
        apb_access(GAIN_ADDR, 1'b0, '0, rd);
        if (rd[GAIN_W-1:0] !== gain) begin
            flag_error($sformatf("gain reads back %0d, wrote %0d", rd[GAIN_W-1:0], gain));
        end
        cur_mode = mode;
        cur_gain = gain;
        settings_used++;
    endtask

    // Offers one request, in bursts separated by random gaps when gaps are
    // on, and records what the block owes once it is accepted.
    task automatic feed_sample(input t_in_req r, input logic typed, input t_out_req want);
        t_out_req predicted;
        if (gaps_on && burst_left == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = $urandom_range(1, 40);
        end
        if (burst_left > 0) begin
            burst_left--;
        end
        i_in_valid <= 1'b1;
        i_in_req   <= r;
        do @(posedge i_clk); while (o_in_stall);
        predicted = smooth_or_average(r);
        filtered_ahead.push_back(typed ? want : predicted);
        requests_fed++;
        mode_hits[cur_mode]++;
        if (r.record_start) begin
            records_opened++;
        end
    endtask

    // Output side: checks every accepted result against the oldest one owed,
    // and stalls in segments of its own: free-running, light, heavy, or one
    // long hold. The stimulus side can ask for a long hold to fill the block.
    initial begin : result_drain
        int       seg_left;
        int       seg_kind;
        int       hold_left;
        t_out_req want;
        seg_left  = 0;
        seg_kind  = 0;
        hold_left = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                if (filtered_ahead.size() == 0) begin
                    flag_error($sformatf("result %0d/%0b with nothing owed",
                                         o_out_req.filtered_out, o_out_req.out_valid));
                end else begin
                    want = filtered_ahead.pop_front();
                    outputs_seen++;
                    if (o_out_req.filtered_out !== want.filtered_out) begin
                        flag_error($sformatf("result %0d: filtered_out %0d, predicted %0d",
                                             outputs_seen, o_out_req.filtered_out,
                                             want.filtered_out));
                    end
                    if (o_out_req.out_valid !== want.out_valid) begin
                        flag_error($sformatf("result %0d: out_valid %0b, predicted %0b",
                                             outputs_seen, o_out_req.out_valid,
                                             want.out_valid));
                    end
                end
            end
            if (hold_req) begin
                hold_left = LONG_HOLD;
                hold_req  = 1'b0;
                holds_done++;
            end
            if (seg_left == 0) begin
                seg_kind = $urandom_range(0, 9);
                seg_left = $urandom_range(20, 200);
                if (seg_kind == 9) begin
                    hold_left = $urandom_range(30, 90);
                end
            end
            seg_left--;
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                case (seg_kind)
                    3, 4, 5: i_out_stall <= ($urandom_range(0, 3) == 0);
                    6, 7, 8: i_out_stall <= ($urandom_range(0, 3) != 0);
                    default: i_out_stall <= 1'b0;
                endcase
            end
        end
    end

    // Stimulus: reset, the directed script, then random phases of records
    // under changing settings, then drain and report.
    initial begin : stimulus
        t_in_req           req;
        logic [MODE_W-1:0] mode;
        logic [GAIN_W-1:0] gain;
        int                rec_left;
        int                waited;
        logic signed [SAMPLE_BITS-1:0] last_x;

        i_rst_n    <= 1'b0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        i_in_valid <= 1'b0;
        i_in_req   <= '0;
        bad_count      = 0;
        outputs_seen   = 0;
        requests_fed   = 0;
        records_opened = 0;
        settings_used  = 1;
        holds_done     = 0;
        mode_hits      = '{0, 0, 0, 0};
        gaps_on        = 1'b1;
        burst_left     = 0;
        hold_req       = 1'b0;
        cur_mode       = MODE_RESET;
        cur_gain       = GAIN_RESET;
        clear_history();

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed script.
        foreach (script[i]) begin
            program_filter(script[i].mode, script[i].gain);
            for (int k = 0; k < script[i].reps; k++) begin
                req.sample_in    = script[i].x;
                req.record_start = script[i].opens && (k == 0);
                feed_sample(req, script[i].typed, script[i].want);
            end
        end

        // Random phases. Records mostly run past the long window so the
        // averages become valid; a few are short, and stray record starts
        // break sequences now and then. Records carry over phase boundaries,
        // which also changes the mode in the middle of a record.
        rec_left = 0;
        last_x   = '0;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case ($urandom_range(0, 9))
                0, 1, 2: mode = MODE_SMOOTH;
                3, 4, 5: mode = MODE_AVG_SHORT;
                6, 7, 8: mode = MODE_AVG_LONG;
                default: mode = MODE_NONE;
            endcase
            case ($urandom_range(0, 7))
                0:       gain = '0;
                1:       gain = 17'd1;
                2:       gain = GAIN_ONE - 17'd1;
                3:       gain = GAIN_ONE;
                4:       gain = GAIN_ONE + 17'd1;
                5:       gain = GAIN_TOP;
                6:       gain = GAIN_W'($urandom_range(0, 65536));
                default: gain = GAIN_W'($urandom);
            endcase
            program_filter(mode, gain);
            gaps_on = (phase % 4 != 1);
            if (phase == PRESSURE_PHASE) begin
                // Keep offering back to back while the output side holds off.
                gaps_on  = 1'b0;
                hold_req = 1'b1;
            end
            for (int n = 0; n < PHASE_REQUESTS; n++) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: req.sample_in = SAMPLE_BITS'($urandom);
                    5, 6:          req.sample_in = SAMPLE_BITS'(int'($urandom_range(0, 128)) - 64);
                    7:             req.sample_in = 16'sh7FFF;
                    8:             req.sample_in = 16'sh8000;
                    default:       req.sample_in = last_x;
                endcase
                last_x = req.sample_in;
                if (rec_left == 0) begin
                    req.record_start = 1'b1;
                    rec_left = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 15)
                                                           : $urandom_range(33, 120);
                end else begin
                    req.record_start = ($urandom_range(0, 149) == 0);
                end
                rec_left--;
                feed_sample(req, 1'b0, '0);
            end
        end

        // Drain: everything owed must arrive, then nothing more may follow.
        i_in_valid <= 1'b0;
        waited = 0;
        while (filtered_ahead.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (filtered_ahead.size() != 0) begin
            flag_error($sformatf("%0d results never arrived", filtered_ahead.size()));
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Covered %0d requests, %0d records, %0d settings, %0d results checked.",
                 requests_fed, records_opened, settings_used, outputs_seen);
        $display("Per mode smooth/short/long/none: %0d/%0d/%0d/%0d; long holds: %0d.",
                 mode_hits[0], mode_hits[1], mode_hits[2], mode_hits[3], holds_done);
        if (bad_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/core/bcs_pkg.sv
rtl/core/bcs_ram.sv
rtl/core/bcs_window.sv
rtl/core/bcs_divide.sv
rtl/core/boxcar_or_first_order_smoother_top.sv
test/tb_boxcar_or_first_order_smoother_top.sv
